// File: rtl/bdb_pkg.sv
// Package for the decimating BMP blit: screen geometry, register indexes and beat types.
// Every module and the checker of the block imports it. It depends on nothing else.
`default_nettype none

package bdb_pkg;

  // Screen geometry.
  localparam int SCREEN_WIDTH  = 800;
  localparam int SCREEN_HEIGHT = 480;

  localparam logic [12:0] SCR_W = 13'(SCREEN_WIDTH);
  localparam logic [12:0] SCR_H = 13'(SCREEN_HEIGHT);

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Output index width and the width of the row * width + column product.
  localparam int IDX_W  = 19;
  localparam int PROD_W = 25;

  // Decoupling queue between the front and back parts.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_X   = 3'd0,
    REG_DEST_Y   = 3'd1,
    REG_WIDTH    = 3'd2,
    REG_HEIGHT   = 3'd3,
    REG_SCALE    = 3'd4
  } cfg_reg_t;

  // Input beat: one source pixel in file byte order.
  typedef struct packed {
    logic       frame_start;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_beat_t;

  // Output beat: one framebuffer write.
  typedef struct packed {
    logic [IDX_W-1:0] write_index;
    logic [23:0]      pixel_rgb;
  } out_beat_t;

  // Derived geometry handed from the geometry unit to the front part.
  typedef struct packed {
    logic [11:0] ox;
    logic [11:0] oy;
    logic [11:0] oy_top;
    logic [11:0] cw;
    logic [11:0] ch;
    logic [11:0] absh;
    logic [11:0] w_m1;
    logic [3:0]  s_m1;
    logic        w_ok;
    logic        flip;
  } geom_t;

  // Queue entry: screen row and column of a kept pixel plus its colour.
  typedef struct packed {
    logic [11:0] row_abs;
    logic [11:0] col_abs;
    logic [23:0] rgb;
  } fifo_item_t;

endpackage

`default_nettype wire

// File: rtl/bmp_decimating_blit.sv
// Top level of the decimating BMP blit: geometry unit, front, queue and back.
// Depends on bdb_pkg, bdb_geom, bdb_front, bdb_fifo and bdb_back.
//
//   Channel | Direction | Handshake               | Payload
//   in_     | input     | in_valid / in_ready     | in_data (frame_start, blue, green, red)
//   out_    | output    | out_valid / out_ready   | out_data (write_index, pixel_rgb)
//   cfg_    | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One pixel beat is taken per cycle while in_ready is high.
// A kept pixel is written into the queue and then into the output register.
// After reset and after every register write, the geometry unit runs one load, twelve
// divide steps and one clip with in_ready low; cfg_ready stays high. The four-entry queue
// lets the front keep taking beats while the output stalls; in_ready drops only when the
// queue is full or the geometry is being derived. Reset is synchronous and active low.
`default_nettype none

module bmp_decimating_blit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bdb_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bdb_pkg::out_beat_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bdb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bdb_pkg::*;

  geom_t      geom;
  logic       geom_ready;
  logic       q_full, q_push, q_pop, q_not_empty;
  fifo_item_t q_in, q_out;

  // Registers and derived geometry.
  bdb_geom u_geom (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .geom       (geom),
    .geom_ready (geom_ready)
  );

  // Source counters and keep decision.
  bdb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .geom       (geom),
    .geom_ready (geom_ready),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_in)
  );

  // Decoupling queue.
  bdb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_out)
  );

  // Index computation and output register.
  bdb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_item      (q_out),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

// File: rtl/bdb_geom.sv
// Configuration registers and the geometry unit of the decimating blit.
// Depends on bdb_pkg. Divides width and height by the scale with a restoring divider.
`default_nettype none

module bdb_geom (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bdb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdb_pkg::CFG_DATA_W-1:0] cfg_data,
  output bdb_pkg::geom_t                geom,
  output logic                          geom_ready
);
  import bdb_pkg::*;

  typedef enum logic [3:0] {
    G_LOAD = 4'b0001,
    G_DIV  = 4'b0010,
    G_CLIP = 4'b0100,
    G_DONE = 4'b1000
  } geom_state_t;

  geom_state_t state_r, state_nxt;
  logic [3:0]  step_r, step_nxt;

  logic [12:0] dest_x_r, dest_y_r, height_r;
  logic [11:0] width_r;
  logic [4:0]  scale_r;

  // Divider datapath: dividend shifts out while quotient shifts in.
  logic [11:0] nw_r, nw_nxt, nh_r, nh_nxt;
  logic [4:0]  rw_r, rw_nxt, rh_r, rh_nxt;
  logic [4:0]  div_r, div_nxt;
  geom_t       geom_r, geom_nxt;

  logic [4:0]  s_eff;
  logic [12:0] mag;
  logic [11:0] absh_c;
  logic [16:0] stp_w, stp_h;
  logic [12:0] sum_w, sum_h;

  // One restoring step: returns {remainder, shifted dividend with quotient bit}.
  function automatic logic [16:0] div_step(logic [11:0] n, logic [4:0] r, logic [4:0] d);
    logic [5:0] r2;
    logic [5:0] diff;
    r2   = {r, n[11]};
    diff = r2 - {1'b0, d};
    if (r2 >= {1'b0, d}) begin
      div_step = {diff[4:0], n[10:0], 1'b1};
    end else begin
      div_step = {r2[4:0], n[10:0], 1'b0};
    end
  endfunction

  // Clamp a signed origin into 0..limit-1.
  function automatic logic [11:0] clamp_org(logic [12:0] v, logic [12:0] lim);
    logic [12:0] top;
    top = lim - 13'd1;
    if (v[12]) begin
      clamp_org = 12'd0;
    end else if (v >= lim) begin
      clamp_org = top[11:0];
    end else begin
      clamp_org = v[11:0];
    end
  endfunction

  assign cfg_ready  = 1'b1;
  assign geom       = geom_r;
  assign geom_ready = (state_r == G_DONE);

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_x_r <= '0;
      dest_y_r <= '0;
      width_r  <= '0;
      height_r <= '0;
      scale_r  <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEST_X: dest_x_r <= cfg_data[12:0];
        REG_DEST_Y: dest_y_r <= cfg_data[12:0];
        REG_WIDTH:  width_r  <= cfg_data[11:0];
        REG_HEIGHT: height_r <= cfg_data[12:0];
        REG_SCALE:  scale_r  <= cfg_data[4:0];
        default:    ;
      endcase
    end
  end

  // Scale clamped to 1..16, height magnitude clamped to 4095.
  always_comb begin
    if (scale_r == 5'd0) begin
      s_eff = 5'd1;
    end else if (scale_r > 5'd16) begin
      s_eff = 5'd16;
    end else begin
      s_eff = scale_r;
    end
    mag    = height_r[12] ? (~height_r + 13'd1) : height_r;
    absh_c = mag[12] ? 12'hFFF : mag[11:0];
    stp_w  = div_step(nw_r, rw_r, div_r);
    stp_h  = div_step(nh_r, rh_r, div_r);
    sum_w  = {1'b0, geom_r.ox} + {1'b0, nw_r};
    sum_h  = {1'b0, geom_r.oy} + {1'b0, nh_r};
  end

  // Sequencer: load, twelve divide steps, clip, then hold the result.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    nw_nxt    = nw_r;
    nh_nxt    = nh_r;
    rw_nxt    = rw_r;
    rh_nxt    = rh_r;
    div_nxt   = div_r;
    geom_nxt  = geom_r;
    case (state_r)
      G_LOAD: begin
        nw_nxt        = width_r;
        nh_nxt        = absh_c;
        rw_nxt        = '0;
        rh_nxt        = '0;
        div_nxt       = s_eff;
        step_nxt      = '0;
        geom_nxt.ox   = clamp_org(dest_x_r, SCR_W);
        geom_nxt.oy   = clamp_org(dest_y_r, SCR_H);
        geom_nxt.absh = absh_c;
        geom_nxt.w_m1 = width_r - 12'd1;
        geom_nxt.s_m1 = 4'(s_eff - 5'd1);
        geom_nxt.w_ok = (width_r != 12'd0) && (width_r[1:0] == 2'b00);
        geom_nxt.flip = !height_r[12] && (height_r != 13'd0);
        state_nxt     = G_DIV;
      end
      G_DIV: begin
        {rw_nxt, nw_nxt} = stp_w;
        {rh_nxt, nh_nxt} = stp_h;
        step_nxt         = step_r + 4'd1;
        if (step_r == 4'd11) begin
          state_nxt = G_CLIP;
        end
      end
      G_CLIP: begin
        geom_nxt.cw     = (sum_w > SCR_W) ? 12'(SCR_W - {1'b0, geom_r.ox}) : nw_r;
        geom_nxt.ch     = (sum_h > SCR_H) ? 12'(SCR_H - {1'b0, geom_r.oy}) : nh_r;
        // Last screen row of the clipped image, the base of the vertical flip.
        geom_nxt.oy_top = (sum_h > SCR_H) ? 12'(SCR_H - 13'd1) : 12'(sum_h - 13'd1);
        state_nxt       = G_DONE;
      end
      G_DONE: ;
      default: state_nxt = G_LOAD;
    endcase
    // Any register write restarts the derivation.
    if (cfg_valid && cfg_ready) begin
      state_nxt = G_LOAD;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_LOAD;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    nw_r   <= nw_nxt;
    nh_r   <= nh_nxt;
    rw_r   <= rw_nxt;
    rh_r   <= rh_nxt;
    div_r  <= div_nxt;
    geom_r <= geom_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/bdb_front.sv
// Front part of the decimating blit: source counters and the keep/clip decision.
// Depends on bdb_pkg. Pushes kept pixels with their screen row and column into the queue.
`default_nettype none

module bdb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bdb_pkg::in_beat_t   in_data,
  input  bdb_pkg::geom_t      geom,
  input  logic                geom_ready,
  input  logic                q_full,
  output logic                q_push,
  output bdb_pkg::fifo_item_t q_item
);
  import bdb_pkg::*;

  logic [11:0] scol_r, scol_nxt, srow_r, srow_nxt, ocol_r, ocol_nxt, orow_r, orow_nxt;
  logic [3:0]  cph_r, cph_nxt, rph_r, rph_nxt;

  logic [11:0] scol, srow, ocol, orow;
  logic [3:0]  cph, rph;
  logic        accept, live, keep;

  assign in_ready = geom_ready && !q_full;
  assign accept   = in_valid && in_ready;

  // A frame start clears the counters before the pixel is judged.
  always_comb begin
    scol = in_data.frame_start ? 12'd0 : scol_r;
    srow = in_data.frame_start ? 12'd0 : srow_r;
    ocol = in_data.frame_start ? 12'd0 : ocol_r;
    orow = in_data.frame_start ? 12'd0 : orow_r;
    cph  = in_data.frame_start ? 4'd0  : cph_r;
    rph  = in_data.frame_start ? 4'd0  : rph_r;
    live = geom.w_ok && (srow < geom.absh);
    keep = live && (cph == 4'd0) && (rph == 4'd0) && (ocol < geom.cw) && (orow < geom.ch);
  end

  // Kept pixel: screen row, flipped for bottom-up images, and screen column.
  always_comb begin
    q_push         = accept && keep;
    q_item.row_abs = geom.flip ? (geom.oy_top - orow) : (geom.oy + orow);
    q_item.col_abs = geom.ox + ocol;
    q_item.rgb     = {in_data.red, in_data.green, in_data.blue};
  end

  // Counter advance for a pixel inside the image.
  always_comb begin
    scol_nxt = scol;
    srow_nxt = srow;
    ocol_nxt = ocol;
    orow_nxt = orow;
    cph_nxt  = cph;
    rph_nxt  = rph;
    if (live) begin
      if (scol >= geom.w_m1) begin
        scol_nxt = '0;
        cph_nxt  = '0;
        ocol_nxt = '0;
        srow_nxt = srow + 12'd1;
        if (rph >= geom.s_m1) begin
          rph_nxt  = '0;
          orow_nxt = orow + 12'd1;
        end else begin
          rph_nxt  = rph + 4'd1;
        end
      end else begin
        scol_nxt = scol + 12'd1;
        if (cph >= geom.s_m1) begin
          cph_nxt  = '0;
          ocol_nxt = ocol + 12'd1;
        end else begin
          cph_nxt  = cph + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scol_r <= '0;
      srow_r <= '0;
      ocol_r <= '0;
      orow_r <= '0;
      cph_r  <= '0;
      rph_r  <= '0;
    end else if (accept) begin
      scol_r <= scol_nxt;
      srow_r <= srow_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
      cph_r  <= cph_nxt;
      rph_r  <= rph_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bdb_fifo.sv
// Short queue that decouples the front and back parts of the decimating blit.
// Depends on bdb_pkg for the entry type and depth.
`default_nettype none

module bdb_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bdb_pkg::fifo_item_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output bdb_pkg::fifo_item_t pop_item
);
  import bdb_pkg::*;

  fifo_item_t           mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0]   count_r;

  assign full      = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + FIFO_CW'(1);
        2'b01:   count_r <= count_r - FIFO_CW'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/bdb_back.sv
// Back part of the decimating blit: framebuffer index and the output register.
// Depends on bdb_pkg. Computes row times screen width plus column on each pop.
`default_nettype none

module bdb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_not_empty,
  input  bdb_pkg::fifo_item_t q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output bdb_pkg::out_beat_t  out_data
);
  import bdb_pkg::*;

  localparam logic [PROD_W-1:0] SW_P = PROD_W'(SCREEN_WIDTH);

  logic               out_valid_r;
  out_beat_t          out_data_r, out_data_nxt;
  logic [PROD_W-1:0]  prod;

  assign q_pop     = q_not_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Constant multiply and add; the index is kept to its low bits.
  always_comb begin
    prod                     = PROD_W'(q_item.row_abs) * SW_P + PROD_W'(q_item.col_abs);
    out_data_nxt.write_index = prod[IDX_W-1:0];
    out_data_nxt.pixel_rgb   = q_item.rgb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bdb_checker.sv
// Port-level checks for the decimating BMP blit, bound to the top level.
// Depends on bdb_pkg for the output beat type.
`default_nettype none

module bdb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic               out_valid,
  input logic               out_ready,
  input bdb_pkg::out_beat_t out_data
);
  import bdb_pkg::*;

  // A stalled output beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // Reset empties the output and blocks input while geometry is derived.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("block not quiet after reset");

  // A register write restarts the geometry unit, so input is held off next cycle.
  a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input taken right after a register write");

endmodule

bind bmp_decimating_blit bdb_checker u_bdb_checker (.*);

`default_nettype wire
